/* design/four_tap_chorus_delay_unit_macros.svh */
// Assertion macros shared by the chorus delay unit.
`ifndef FOUR_TAP_CHORUS_DELAY_UNIT_MACROS_SVH
`define FOUR_TAP_CHORUS_DELAY_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FTCD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ftcd assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FTCD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ftcd assertion failed");

`endif

/* design/ftcd_pkg.sv */
// Package with the constants and control types of the chorus delay unit.
package ftcd_pkg;

    localparam int RING_DEPTH = 4096;
    localparam int ADDR_W     = $clog2(RING_DEPTH);
    localparam int FRAC_BITS  = 8;
    localparam int DELAY_W    = 20;
    localparam int SAMPLE_W   = 16;
    localparam int WET_W      = 13;
    localparam int GAIN_W     = 16;
    localparam int NUM_TAPS   = 4;
    localparam int RD_COUNT   = 2 * NUM_TAPS;
    localparam int RD_IDX_W   = $clog2(RD_COUNT);
    localparam int TAP_IDX_W  = $clog2(NUM_TAPS);

    localparam logic [WET_W-1:0]     WET_ONE    = 13'd4096;
    localparam logic [GAIN_W-1:0]    GAIN_RESET = 16'd4096;
    localparam logic [FRAC_BITS:0]   FRAC_ONE   = 9'd256;

    localparam int WEIGHT_W   = FRAC_BITS + 1;
    localparam int TPROD_W    = SAMPLE_W + WEIGHT_W + 1;
    localparam int ACC_W      = TPROD_W + 1;
    localparam int P1_W       = ACC_W + WET_W + 1;
    localparam int P2_W       = SAMPLE_W + WET_W + 1;
    localparam int MIX_W      = P1_W;
    localparam int MIX_SHIFT  = FRAC_BITS + 2;
    localparam int M_W        = MIX_W - MIX_SHIFT;
    localparam int PROD_W     = M_W + GAIN_W + 1;
    localparam int GAIN_SHIFT = 24;
    localparam int Y_W        = PROD_W - GAIN_SHIFT;

    typedef struct packed {
        logic                load;
        logic                rd_en;
        logic [RD_IDX_W-1:0] rd_idx;
        logic                mix;
        logic                round;
        logic                mult;
        logic                advance;
        logic                out_load;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

endpackage

/* design/ftcd_ctrl.sv */
// Controller state machine that sequences the ring reads and the mix steps.
module ftcd_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  ftcd_pkg::status_t status,
    output ftcd_pkg::cmd_t   cmd
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_READ  = 3'd1;
    localparam logic [2:0] ST_DRAIN = 3'd2;
    localparam logic [2:0] ST_MIX   = 3'd3;
    localparam logic [2:0] ST_RND   = 3'd4;
    localparam logic [2:0] ST_MUL   = 3'd5;
    localparam logic [2:0] ST_DONE  = 3'd6;

    logic [2:0]                    state_reg, state_next;
    logic [ftcd_pkg::RD_IDX_W-1:0] cnt_reg, cnt_next;

    always_comb begin
        cmd        = '0;
        s_ready    = 1'b0;
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_idx = cnt_reg;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == ftcd_pkg::RD_IDX_W'(ftcd_pkg::RD_COUNT - 1)) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_MIX;
            end
            ST_MIX: begin
                cmd.mix    = 1'b1;
                state_next = ST_RND;
            end
            ST_RND: begin
                cmd.round  = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mult    = 1'b1;
                cmd.advance = 1'b1;
                state_next  = ST_DONE;
            end
            ST_DONE: begin
                if (!status.out_busy) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

/* design/ftcd_datapath.sv */
// Datapath with the history ring, tap interpolation, mix, gain and output register.
module ftcd_datapath (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  ftcd_pkg::cmd_t                       cmd,
    output ftcd_pkg::status_t                    status,
    input  logic signed [ftcd_pkg::SAMPLE_W-1:0] s_sample_in,
    input  logic        [ftcd_pkg::WET_W-1:0]    s_wet_amount,
    input  logic        [ftcd_pkg::DELAY_W-1:0]  s_delay_one,
    input  logic        [ftcd_pkg::DELAY_W-1:0]  s_delay_two,
    input  logic        [ftcd_pkg::DELAY_W-1:0]  s_delay_three,
    input  logic        [ftcd_pkg::DELAY_W-1:0]  s_delay_four,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [ftcd_pkg::GAIN_W-1:0]   cfg_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ftcd_pkg::SAMPLE_W-1:0] m_sample_out
);

    logic signed [ftcd_pkg::SAMPLE_W-1:0] ring_mem [ftcd_pkg::RING_DEPTH];

    logic        [ftcd_pkg::ADDR_W-1:0]   wp_reg;
    logic                                 full_reg;
    logic        [ftcd_pkg::GAIN_W-1:0]   gain_reg;
    logic                                 mac_reg;
    logic                                 m_valid_reg;

    logic signed [ftcd_pkg::SAMPLE_W-1:0] dry_reg;
    logic        [ftcd_pkg::WET_W-1:0]    wet_reg;
    logic        [ftcd_pkg::DELAY_W-1:0]  delay_reg [ftcd_pkg::NUM_TAPS];
    logic signed [ftcd_pkg::SAMPLE_W-1:0] rdata_reg;
    logic                                 rvalid_reg;
    logic        [ftcd_pkg::WEIGHT_W-1:0] weight_reg;
    logic signed [ftcd_pkg::ACC_W-1:0]    acc_reg, acc_next;
    logic signed [ftcd_pkg::P1_W-1:0]     p1_reg;
    logic signed [ftcd_pkg::P2_W-1:0]     p2_reg;
    logic signed [ftcd_pkg::M_W-1:0]      m_reg, m_next;
    logic signed [ftcd_pkg::PROD_W-1:0]   prod_reg;
    logic signed [ftcd_pkg::SAMPLE_W-1:0] out_reg, out_next;

    logic        [ftcd_pkg::TAP_IDX_W-1:0] tap_sel;
    logic                                  second_sel;
    logic        [ftcd_pkg::ADDR_W-1:0]    ipart;
    logic        [ftcd_pkg::FRAC_BITS-1:0] fpart;
    logic        [ftcd_pkg::ADDR_W-1:0]    rd_addr;
    logic        [ftcd_pkg::WEIGHT_W-1:0]  weight;
    logic                                  rd_valid;
    logic        [ftcd_pkg::WET_W-1:0]     wet_clamped;
    logic signed [ftcd_pkg::SAMPLE_W-1:0]  tap_sample;
    logic signed [ftcd_pkg::TPROD_W-1:0]   tap_prod;
    logic signed [ftcd_pkg::MIX_W-1:0]     mix_sum;
    logic signed [ftcd_pkg::PROD_W-1:0]    prod_round;
    logic signed [ftcd_pkg::Y_W-1:0]       y_val;

    assign cfg_ready     = 1'b1;
    assign m_valid       = m_valid_reg;
    assign m_sample_out  = out_reg;
    assign status.out_busy = m_valid_reg && !m_ready;

    assign wet_clamped = (s_wet_amount > ftcd_pkg::WET_ONE) ? ftcd_pkg::WET_ONE : s_wet_amount;

    // The second read of each tap is the entry one before the first.
    always_comb begin
        tap_sel    = cmd.rd_idx[ftcd_pkg::RD_IDX_W-1:1];
        second_sel = cmd.rd_idx[0];
        ipart      = delay_reg[tap_sel][ftcd_pkg::FRAC_BITS +: ftcd_pkg::ADDR_W];
        fpart      = delay_reg[tap_sel][ftcd_pkg::FRAC_BITS-1:0];
        rd_addr    = wp_reg - ipart - ftcd_pkg::ADDR_W'(second_sel);
        weight     = second_sel ? {1'b0, fpart} : (ftcd_pkg::FRAC_ONE - {1'b0, fpart});
        // Entries are written in address order, so anything past the pointer
        // before the first wrap has not been written yet and is read as zero.
        rd_valid   = full_reg || (rd_addr <= wp_reg);
    end

    always_comb begin
        tap_sample = rvalid_reg ? rdata_reg : '0;
        tap_prod   = ftcd_pkg::TPROD_W'(tap_sample)
                   * ftcd_pkg::TPROD_W'($signed({1'b0, weight_reg}));
        acc_next   = acc_reg + ftcd_pkg::ACC_W'(tap_prod);
        mix_sum    = p1_reg + (ftcd_pkg::MIX_W'(p2_reg) <<< ftcd_pkg::MIX_SHIFT)
                   + (ftcd_pkg::MIX_W'(1) <<< (ftcd_pkg::MIX_SHIFT - 1));
        m_next     = ftcd_pkg::M_W'(mix_sum >>> ftcd_pkg::MIX_SHIFT);
        prod_round = prod_reg + (ftcd_pkg::PROD_W'(1) <<< (ftcd_pkg::GAIN_SHIFT - 1));
        y_val      = ftcd_pkg::Y_W'(prod_round >>> ftcd_pkg::GAIN_SHIFT);
        if (y_val > ftcd_pkg::Y_W'(32767)) begin
            out_next = 16'sh7FFF;
        end else if (y_val < -ftcd_pkg::Y_W'(32768)) begin
            out_next = 16'sh8000;
        end else begin
            out_next = ftcd_pkg::SAMPLE_W'(y_val);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ring_mem[wp_reg] <= s_sample_in;
        end
        if (cmd.rd_en) begin
            rdata_reg <= ring_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg      <= '0;
            full_reg    <= 1'b0;
            gain_reg    <= ftcd_pkg::GAIN_RESET;
            mac_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            mac_reg <= cmd.rd_en;
            if (cfg_valid) begin
                gain_reg <= cfg_data;
            end
            if (cmd.advance) begin
                wp_reg <= wp_reg + 1'b1;
                if (wp_reg == ftcd_pkg::ADDR_W'(ftcd_pkg::RING_DEPTH - 1)) begin
                    full_reg <= 1'b1;
                end
            end
            if (cmd.out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            dry_reg      <= s_sample_in;
            wet_reg      <= wet_clamped;
            delay_reg[0] <= s_delay_one;
            delay_reg[1] <= s_delay_two;
            delay_reg[2] <= s_delay_three;
            delay_reg[3] <= s_delay_four;
            acc_reg      <= '0;
        end else if (mac_reg) begin
            acc_reg <= acc_next;
        end
        if (cmd.rd_en) begin
            rvalid_reg <= rd_valid;
            weight_reg <= weight;
        end
        if (cmd.mix) begin
            p1_reg <= ftcd_pkg::P1_W'(acc_reg) * ftcd_pkg::P1_W'($signed({1'b0, wet_reg}));
            p2_reg <= ftcd_pkg::P2_W'(dry_reg)
                    * ftcd_pkg::P2_W'($signed({1'b0, ftcd_pkg::WET_ONE - wet_reg}));
        end
        if (cmd.round) begin
            m_reg <= m_next;
        end
        if (cmd.mult) begin
            prod_reg <= ftcd_pkg::PROD_W'(m_reg) * ftcd_pkg::PROD_W'($signed({1'b0, gain_reg}));
        end
        if (cmd.out_load) begin
            out_reg <= out_next;
        end
    end

endmodule

/* design/four_tap_chorus_delay_unit.sv */
// Top level of the four-voice chorus delay unit.
//
//   Channel   Ports                                     Moves
//   input     s_valid, s_ready, s_sample_in ...         one dry item with wet and delays
//   output    m_valid, m_ready, m_sample_out            one mixed item per input item
//   config    cfg_valid, cfg_ready, cfg_data            output gain, Q4.12
//
// The accepting edge writes the ring, the eight tap reads go through the one ring port,
// and five steps drain, mix, round, scale and load the result.
// s_ready returns the cycle after the load, so no new item is accepted while one is in flight.
// Reset is synchronous, active low; unwritten ring entries read as zero, so no clearing
// pass runs and an item is accepted right after reset.
// A stalled result holds the next finished item in its last step until the output is free.
`include "four_tap_chorus_delay_unit_macros.svh"

module four_tap_chorus_delay_unit (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [ftcd_pkg::SAMPLE_W-1:0] s_sample_in,
    input  logic        [ftcd_pkg::WET_W-1:0]    s_wet_amount,
    input  logic        [ftcd_pkg::DELAY_W-1:0]  s_delay_one,
    input  logic        [ftcd_pkg::DELAY_W-1:0]  s_delay_two,
    input  logic        [ftcd_pkg::DELAY_W-1:0]  s_delay_three,
    input  logic        [ftcd_pkg::DELAY_W-1:0]  s_delay_four,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [ftcd_pkg::SAMPLE_W-1:0] m_sample_out,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic        [ftcd_pkg::GAIN_W-1:0]   cfg_data
);

    ftcd_pkg::cmd_t    cmd;
    ftcd_pkg::status_t status;

    ftcd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ftcd_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_sample_in   (s_sample_in),
        .s_wet_amount  (s_wet_amount),
        .s_delay_one   (s_delay_one),
        .s_delay_two   (s_delay_two),
        .s_delay_three (s_delay_three),
        .s_delay_four  (s_delay_four),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out)
    );

    `FTCD_ASSERT_NEXT(a_no_back_to_back, aclk, aresetn, s_valid && s_ready, !s_ready)
    `FTCD_ASSERT_NOW(a_load_on_accept, aclk, aresetn, cmd.load, s_valid && s_ready)
    `FTCD_ASSERT_NOW(a_out_load_free, aclk, aresetn, cmd.out_load, !(m_valid && !m_ready))

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the four-voice chorus delay unit, with its own chorus predictor.
module tb_top;

    typedef struct packed {
        logic [ftcd_pkg::SAMPLE_W-1:0]                       sample;
        logic [ftcd_pkg::WET_W-1:0]                          wet;
        logic [ftcd_pkg::NUM_TAPS-1:0][ftcd_pkg::DELAY_W-1:0] delay;
    } chorus_item_t;

    logic                                 aclk          = 1'b0;
    logic                                 aresetn       = 1'b0;
    logic                                 s_valid       = 1'b0;
    wire                                  s_ready;
    logic signed [ftcd_pkg::SAMPLE_W-1:0] s_sample_in   = '0;
    logic [ftcd_pkg::WET_W-1:0]           s_wet_amount  = '0;
    logic [ftcd_pkg::DELAY_W-1:0]         s_delay_one   = '0;
    logic [ftcd_pkg::DELAY_W-1:0]         s_delay_two   = '0;
    logic [ftcd_pkg::DELAY_W-1:0]         s_delay_three = '0;
    logic [ftcd_pkg::DELAY_W-1:0]         s_delay_four  = '0;
    wire                                  m_valid;
    logic                                 m_ready       = 1'b0;
    wire signed [ftcd_pkg::SAMPLE_W-1:0]  m_sample_out;
    logic                                 cfg_valid     = 1'b0;
    wire                                  cfg_ready;
    logic [ftcd_pkg::GAIN_W-1:0]          cfg_data      = '0;

    logic signed [ftcd_pkg::SAMPLE_W-1:0] ring_model [ftcd_pkg::RING_DEPTH];
    logic [ftcd_pkg::ADDR_W-1:0]          wr_ptr_model = '0;
    int                                   gain_model   = int'(ftcd_pkg::GAIN_RESET);

    chorus_item_t                         pending_items [$];
    logic signed [ftcd_pkg::SAMPLE_W-1:0] expected_samples [$];
    chorus_item_t                         held_item;
    logic signed [ftcd_pkg::SAMPLE_W-1:0] want_sample;
    int                                   items_queued    = 0;
    int                                   results_checked = 0;
    int                                   error_count     = 0;
    int                                   send_gap        = 0;
    int                                   recv_stall      = 0;
    bit                                   quiet_run       = 1'b0;

    four_tap_chorus_delay_unit i_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample_in   (s_sample_in),
        .s_wet_amount  (s_wet_amount),
        .s_delay_one   (s_delay_one),
        .s_delay_two   (s_delay_two),
        .s_delay_three (s_delay_three),
        .s_delay_four  (s_delay_four),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_sample_out  (m_sample_out),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    function automatic logic signed [ftcd_pkg::SAMPLE_W-1:0] chorus_output(
        input chorus_item_t it);
        longint                      tap_sum;
        longint                      mix;
        longint                      mixed;
        longint                      scaled;
        longint                      dry;
        longint                      wet;
        longint                      near_tap;
        longint                      far_tap;
        logic [ftcd_pkg::ADDR_W-1:0] ipart;
        logic [ftcd_pkg::ADDR_W-1:0] near_idx;
        logic [ftcd_pkg::ADDR_W-1:0] far_idx;
        int                          frac;
        int                          k;
        dry = longint'($signed(it.sample));
        wet = (it.wet > ftcd_pkg::WET_ONE) ? longint'(ftcd_pkg::WET_ONE) : longint'(it.wet);
        ring_model[wr_ptr_model] = $signed(it.sample);
        tap_sum = 0;
        for (k = 0; k < ftcd_pkg::NUM_TAPS; k++) begin
            ipart    = it.delay[k][ftcd_pkg::FRAC_BITS +: ftcd_pkg::ADDR_W];
            frac     = int'(it.delay[k][ftcd_pkg::FRAC_BITS-1:0]);
            near_idx = wr_ptr_model - ipart;
            far_idx  = near_idx - 1'b1;
            near_tap = longint'(ring_model[near_idx]);
            far_tap  = longint'(ring_model[far_idx]);
            tap_sum += near_tap * longint'((1 << ftcd_pkg::FRAC_BITS) - frac)
                     + far_tap * longint'(frac);
        end
        mix    = tap_sum * wet + dry * (longint'(ftcd_pkg::WET_ONE) - wet)
               * longint'(4 << ftcd_pkg::FRAC_BITS);
        mixed  = (mix + (longint'(1) << (ftcd_pkg::MIX_SHIFT - 1))) >>> ftcd_pkg::MIX_SHIFT;
        scaled = (mixed * longint'(gain_model) + (longint'(1) << (ftcd_pkg::GAIN_SHIFT - 1)))
                 >>> ftcd_pkg::GAIN_SHIFT;
        if (scaled > 32767) begin
            scaled = 32767;
        end
        if (scaled < -32768) begin
            scaled = -32768;
        end
        wr_ptr_model = wr_ptr_model + 1'b1;
        return scaled[ftcd_pkg::SAMPLE_W-1:0];
    endfunction

    function automatic chorus_item_t make_item(input int smp, input int wet, input int d1,
                                               input int d2, input int d3, input int d4);
        chorus_item_t it;
        it.sample   = ftcd_pkg::SAMPLE_W'(smp);
        it.wet      = ftcd_pkg::WET_W'(wet);
        it.delay[0] = ftcd_pkg::DELAY_W'(d1);
        it.delay[1] = ftcd_pkg::DELAY_W'(d2);
        it.delay[2] = ftcd_pkg::DELAY_W'(d3);
        it.delay[3] = ftcd_pkg::DELAY_W'(d4);
        return it;
    endfunction

    function automatic chorus_item_t random_item();
        chorus_item_t it;
        int           k;
        int           pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            it.sample = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
        end else begin
            it.sample = ftcd_pkg::SAMPLE_W'($urandom);
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            it.wet = ftcd_pkg::WET_W'($urandom_range(int'(ftcd_pkg::WET_ONE) + 1,
                                                     (1 << ftcd_pkg::WET_W) - 1));
        end else if (pick == 1) begin
            it.wet = $urandom_range(0, 1) ? ftcd_pkg::WET_ONE : '0;
        end else begin
            it.wet = ftcd_pkg::WET_W'($urandom_range(0, int'(ftcd_pkg::WET_ONE)));
        end
        for (k = 0; k < ftcd_pkg::NUM_TAPS; k++) begin
            pick = $urandom_range(0, 7);
            case (pick)
                0: begin
                    it.delay[k] = '0;
                end
                1: begin
                    it.delay[k] = ftcd_pkg::DELAY_W'($urandom_range(0, 1023));
                end
                2: begin
                    it.delay[k] = '1;
                end
                default: begin
                    it.delay[k] = ftcd_pkg::DELAY_W'($urandom);
                end
            endcase
        end
        return it;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    task automatic queue_item(input chorus_item_t it);
        pending_items.push_back(it);
        items_queued++;
    endtask

    task automatic queue_random(input int count);
        repeat (count) begin
            queue_item(random_item());
        end
    endtask

    task automatic wait_drained();
        while (results_checked != items_queued) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_gain(input logic [ftcd_pkg::GAIN_W-1:0] gain);
        @(posedge aclk);
        cfg_data  <= gain;
        cfg_valid <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!cfg_ready);
        cfg_valid  <= 1'b0;
        gain_model = int'(gain);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid  <= 1'b0;
            send_gap = 0;
        end else begin
            if (s_valid && s_ready) begin
                expected_samples.push_back(chorus_output(held_item));
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    held_item     = pending_items.pop_front();
                    s_valid       <= 1'b1;
                    s_sample_in   <= held_item.sample;
                    s_wet_amount  <= held_item.wet;
                    s_delay_one   <= held_item.delay[0];
                    s_delay_two   <= held_item.delay[1];
                    s_delay_three <= held_item.delay[2];
                    s_delay_four  <= held_item.delay[3];
                    if (!quiet_run && $urandom_range(0, 7) == 0) begin
                        send_gap = $urandom_range(1, 6);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready    <= 1'b0;
            recv_stall = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_samples.size() == 0) begin
                    report_mismatch("sample_out with no item outstanding",
                                    int'(m_sample_out), 0);
                end else begin
                    want_sample = expected_samples.pop_front();
                    if (m_sample_out !== want_sample) begin
                        report_mismatch("sample_out", int'(m_sample_out), int'(want_sample));
                    end
                end
                results_checked++;
            end
            if (recv_stall > 0) begin
                recv_stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if (!quiet_run && $urandom_range(0, 7) == 0) begin
                    recv_stall = $urandom_range(1, 6);
                end
            end
        end
    end

    initial begin
        #6_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        foreach (ring_model[i]) begin
            ring_model[i] = '0;
        end
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        queue_item(make_item(32767, 0, 0, 0, 0, 0));
        queue_item(make_item(-32768, 4096, 0, 0, 0, 0));
        queue_item(make_item(32767, 4096, 0, 0, 0, 0));
        queue_item(make_item(-32768, 8191, 'hFFFFF, 'hFFFFF, 'hFFFFF, 'hFFFFF));
        queue_item(make_item(12345, 4097, 1, 2, 3, 4));
        queue_item(make_item(-1, 2048, 256, 512, 768, 1024));
        queue_item(make_item('h5555, 'h0AAA, 'h55555, 'hAAAAA, 'h0F0F0, 'hF0F0F));
        queue_item(make_item('hAAAA, 'h1555, 'hAAAAA, 'h55555, 'hF0F0F, 'h0F0F0));
        queue_item(make_item(100, 4096, 'h000FF, 'h00100, 'h001FF, 'hFFF00));
        queue_item(make_item(-100, 1, 'hFFF80, 'h00080, 'h7FF80, 'h80080));
        wait_drained();

        write_gain(16'hFFFF);
        queue_item(make_item(32767, 0, 0, 0, 0, 0));
        queue_item(make_item(-32768, 0, 0, 0, 0, 0));
        queue_item(make_item(1, 0, 0, 0, 0, 0));
        queue_random(250);
        wait_drained();

        write_gain(16'h0000);
        queue_item(make_item(32767, 4096, 0, 0, 0, 0));
        queue_item(make_item(-32768, 0, 'h00100, 'h00200, 'h00300, 'h00400));
        queue_random(150);
        wait_drained();

        write_gain(16'h0001);
        queue_random(150);
        wait_drained();

        write_gain(ftcd_pkg::GAIN_W'($urandom_range(0, 65535)));
        queue_random(300);
        wait_drained();
        queue_random(300);
        wait_drained();

        write_gain(ftcd_pkg::GAIN_RESET);
        queue_random(200);
        while (pending_items.size() > 0) begin
            @(posedge aclk);
        end
        quiet_run = 1'b1;
        queue_random(150);
        wait_drained();

        repeat (40) @(posedge aclk);
        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
